/* hw/rtl/udpdm_pkg.sv */
package udpdm_pkg;

  typedef enum logic [1:0] {
    OP_BIND    = 2'd0,
    OP_DELIVER = 2'd1,
    OP_RECEIVE = 2'd2,
    OP_NOP     = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_ALREADY    = 4'd1,
    ST_FULL_TABLE = 4'd2,
    ST_NOT_BOUND  = 4'd3,
    ST_SHORT      = 4'd4,
    ST_NOT_UDP    = 4'd5,
    ST_BAD_LEN    = 4'd6,
    ST_QUEUE_FULL = 4'd7,
    ST_EMPTY      = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EXEC,
    BK_READ,
    BK_DONE
  } back_state_e;

  localparam logic [12:0] HdrBytes    = 13'd42;
  localparam logic [15:0] UdpHdrBytes = 16'd8;
  localparam logic [7:0]  ProtoUdp    = 8'd17;

  // classified command passed from front to back
  typedef struct packed {
    opcode_e     op;
    logic [15:0] port;
    logic        pre_fail;
    status_e     pre_status;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [15:0] pay_len;
    logic [15:0] max_len;
  } cmd_t;

endpackage

/* hw/rtl/udp_port_demux_queues.sv */
// UDP port demultiplexer: bind, deliver and receive commands on one valid/ready
// input channel, one status beat per command on the output. A front stage runs
// the frame header checks and holds up to two commands; the back sequencer scans
// the NUM_PORTS-entry port table one slot per cycle, then updates the port table
// or the per-port queue. A command passes the scan, execute and done states, and
// its result is held on the output until taken; the back sequencer takes no new
// command while a result waits. A receive that pops adds a read state for the
// descriptor RAM read. Header rejects and opcode 3 skip the scan and give their status from idle.
module udp_port_demux_queues #(
  parameter int NUM_PORTS   = 16,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [15:0] port_i,
  input  logic [12:0] frame_len_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [31:0] source_ip_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] udp_length_i,
  input  logic [15:0] max_len_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [31:0] rx_source_ip_o,
  output logic [15:0] rx_source_port_o,
  output logic [15:0] copy_length_o
);
  import udpdm_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  udpdm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .opcode_i, .port_i,
    .frame_len_i, .ip_protocol_i, .source_ip_i, .source_port_i,
    .udp_length_i, .max_len_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  udpdm_back #(.NumPorts(NUM_PORTS), .QueueDepth(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .out_valid_o, .out_ready_i, .status_o, .rx_source_ip_o,
    .rx_source_port_o, .copy_length_o
  );
endmodule

/* hw/rtl/udpdm_ram.sv */
module udpdm_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/udpdm_front.sv */
module udpdm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [15:0]        port_i,
  input  logic [12:0]        frame_len_i,
  input  logic [7:0]         ip_protocol_i,
  input  logic [31:0]        source_ip_i,
  input  logic [15:0]        source_port_i,
  input  logic [15:0]        udp_length_i,
  input  logic [15:0]        max_len_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output udpdm_pkg::cmd_t    cmd_o
);
  import udpdm_pkg::*;

  // two-entry command queue
  cmd_t       buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  cmd_t       cmd_d;
  logic       push, pop;

  // header checks done up front, in priority order: short frame, protocol, UDP length
  always_comb begin
    cmd_d.op          = opcode_e'(opcode_i);
    cmd_d.port        = port_i;
    cmd_d.source_ip   = source_ip_i;
    cmd_d.source_port = source_port_i;
    cmd_d.pay_len     = udp_length_i - UdpHdrBytes;
    cmd_d.max_len     = max_len_i;
    cmd_d.pre_fail    = 1'b0;
    cmd_d.pre_status  = ST_OK;
    if (opcode_e'(opcode_i) == OP_DELIVER) begin
      if (frame_len_i < HdrBytes) begin
        cmd_d.pre_fail = 1'b1; cmd_d.pre_status = ST_SHORT;
      end else if (ip_protocol_i != ProtoUdp) begin
        cmd_d.pre_fail = 1'b1; cmd_d.pre_status = ST_NOT_UDP;
      end else if (udp_length_i < UdpHdrBytes) begin
        cmd_d.pre_fail = 1'b1; cmd_d.pre_status = ST_BAD_LEN;
      end
    end else if (opcode_e'(opcode_i) == OP_NOP) begin
      cmd_d.pre_fail = 1'b1;
    end
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("command queue overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("command count out of range");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("count not tracking");
`endif
endmodule

/* hw/rtl/udpdm_back.sv */
module udpdm_back #(
  parameter int NumPorts   = 16,
  parameter int QueueDepth = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  udpdm_pkg::cmd_t cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [3:0]      status_o,
  output logic [31:0]     rx_source_ip_o,
  output logic [15:0]     rx_source_port_o,
  output logic [15:0]     copy_length_o
);
  import udpdm_pkg::*;

  localparam int SW = (NumPorts > 1) ? $clog2(NumPorts) : 1;
  localparam int QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CW = $clog2(QueueDepth + 1);
  localparam int AW = $clog2(NumPorts * QueueDepth) > 0 ? $clog2(NumPorts * QueueDepth) : 1;
  localparam int MD = (NumPorts * QueueDepth > 1) ? NumPorts * QueueDepth : 2;

  logic [NumPorts-1:0] valid_q;
  logic [15:0]         sport_q [NumPorts];
  logic [CW-1:0]       count_q [NumPorts];
  logic [QW-1:0]       head_q  [NumPorts];
  logic [QW-1:0]       tail_q  [NumPorts];

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic [SW:0] idx_q, idx_d;
  logic        hit_q, hit_d, free_q, free_d;
  logic [SW-1:0] hs_q, hs_d, fs_q, fs_d;

  logic        ov_q, ov_d;
  logic [3:0]  st_q, st_d;
  logic [31:0] ip_q, ip_d;
  logic [15:0] sp_q, sp_d, cl_q, cl_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;
  logic [SW-1:0] cur;
  logic          take, do_bind, do_push, do_pop;

  function automatic logic [QW-1:0] wrap_inc(logic [QW-1:0] v);
    if (QueueDepth == 1) return '0;
    if ({1'b0, v} == (QW+1)'(QueueDepth - 1)) return '0;
    return v + 1'b1;
  endfunction

  udpdm_ram #(.Width(64), .Depth(MD)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign cur   = idx_q[SW-1:0];
  assign take  = cmd_valid_i && cmd_ready_o;
  assign cmd_ready_o = (state_q == BK_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign rx_source_ip_o = ip_q;
  assign rx_source_port_o = sp_q;
  assign copy_length_o = cl_q;

  assign waddr = AW'(hs_q) * AW'(QueueDepth) + AW'(tail_q[hs_q]);
  assign raddr = AW'(hs_q) * AW'(QueueDepth) + AW'(head_q[hs_q]);
  assign wdata = {cmd_q.source_ip, cmd_q.source_port, cmd_q.pay_len};

  // sequencer: scan slots one per cycle, then act
  always_comb begin
    state_d = state_q; idx_d = idx_q; hit_d = hit_q; hs_d = hs_q;
    free_d = free_q; fs_d = fs_q;
    ov_d = ov_q; st_d = st_q; ip_d = ip_q; sp_d = sp_q; cl_d = cl_q;
    we = 1'b0; do_bind = 1'b0; do_push = 1'b0; do_pop = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (take) begin
          idx_d = '0; hit_d = 1'b0; free_d = 1'b0;
          ip_d = '0; sp_d = '0; cl_d = '0;
          if (cmd_i.pre_fail) begin
            st_d = cmd_i.pre_status; ov_d = 1'b1;
          end else begin
            state_d = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (valid_q[cur] && sport_q[cur] == cmd_q.port && !hit_q) begin
          hit_d = 1'b1; hs_d = cur;
        end
        if (!valid_q[cur] && !free_q) begin
          free_d = 1'b1; fs_d = cur;
        end
        if (idx_q == (SW+1)'(NumPorts - 1)) state_d = BK_EXEC;
        idx_d = idx_q + 1'b1;
      end
      BK_EXEC: begin
        state_d = BK_DONE;
        st_d = ST_OK;
        case (cmd_q.op)
          OP_BIND: begin
            if (hit_q) st_d = ST_ALREADY;
            else if (!free_q) st_d = ST_FULL_TABLE;
            else do_bind = 1'b1;
          end
          OP_DELIVER: begin
            if (!hit_q) st_d = ST_NOT_BOUND;
            else if (count_q[hs_q] == CW'(QueueDepth)) st_d = ST_QUEUE_FULL;
            else begin we = 1'b1; do_push = 1'b1; end
          end
          OP_RECEIVE: begin
            if (!hit_q) st_d = ST_NOT_BOUND;
            else if (count_q[hs_q] == '0) st_d = ST_EMPTY;
            else begin do_pop = 1'b1; state_d = BK_READ; end
          end
          default: ;
        endcase
      end
      BK_READ: begin
        state_d = BK_DONE;
        ip_d = rdata[63:32]; sp_d = rdata[31:16];
        cl_d = (rdata[15:0] > cmd_q.max_len) ? cmd_q.max_len : rdata[15:0];
      end
      BK_DONE: begin
        ov_d = 1'b1; state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    ip_q <= ip_d; sp_q <= sp_d; cl_q <= cl_d; st_q <= st_d;
    if (do_bind) sport_q[fs_q] <= cmd_q.port;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE; ov_q <= 1'b0; valid_q <= '0;
      idx_q <= '0; hit_q <= 1'b0; free_q <= 1'b0; hs_q <= '0; fs_q <= '0;
      for (int i = 0; i < NumPorts; i++) begin
        count_q[i] <= '0; head_q[i] <= '0; tail_q[i] <= '0;
      end
    end else begin
      state_q <= state_d; ov_q <= ov_d; idx_q <= idx_d;
      hit_q <= hit_d; free_q <= free_d; hs_q <= hs_d; fs_q <= fs_d;
      if (do_bind) begin
        valid_q[fs_q] <= 1'b1;
        count_q[fs_q] <= '0; head_q[fs_q] <= '0; tail_q[fs_q] <= '0;
      end
      if (do_push) begin
        tail_q[hs_q]  <= wrap_inc(tail_q[hs_q]);
        count_q[hs_q] <= count_q[hs_q] + 1'b1;
      end
      if (do_pop) begin
        head_q[hs_q]  <= wrap_inc(head_q[hs_q]);
        count_q[hs_q] <= count_q[hs_q] - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != BK_IDLE |-> !cmd_ready_o) else $error("command taken while busy");
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({do_bind, do_push, do_pop}) <= 1) else $error("two table updates");
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |-> count_q[hs_q] != '0) else $error("pop from empty queue");
  a_read_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_READ |-> $past(do_pop)) else $error("read without pop");
`endif
endmodule
